// ----- src/pmi_pkg.sv -----
`timescale 1ns / 1ps

package pmi_pkg;

  // Coordinate format and fixed-point widths.
  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 10;
  localparam int LEN_W       = 20;
  localparam int ENT_W       = 21;
  localparam int INV_FRAC    = 19;
  localparam int SBITS       = INV_FRAC + FRAC_BITS;
  localparam int NUM_AXES    = 3;
  localparam int ROW_W       = NUM_AXES * ENT_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTHS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INV_ROW2    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TR_ROW0     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_TR_ROW1     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TR_ROW2     = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_TRIC_MODE   = CFG_IDX_W'(7);

  // Datapath widths.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int T_W    = ((DIFF_W > LEN_W) ? DIFF_W : LEN_W) + 1;
  localparam int WR_W   = T_W + 1;
  localparam int P1_W   = ENT_W + DIFF_W;
  localparam int ACC1_W = P1_W + 2;
  localparam int S_W    = SBITS + 1;
  localparam int P2_W   = ENT_W + S_W;
  localparam int ACC2_W = P2_W + 2;
  localparam int WIDE_W = ((ACC1_W > ACC2_W) ? ACC1_W : ACC2_W) + 1;

  // Pipeline depth: input register, lane stages, two merge stages.
  localparam int LANE_LAT  = T_W + 2;
  localparam int MERGE_LAT = 2;
  localparam int PIPE_LEN  = 1 + LANE_LAT + MERGE_LAT;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [ENT_W-1:0]       ent_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef logic [NUM_AXES-1:0][ROW_W-1:0] rows_t;

  typedef struct packed {
    logic [NUM_AXES*LEN_W-1:0] box_lengths;
    rows_t                     inv_rows;
    rows_t                     tr_rows;
    logic                      triclinic_mode;
  } cfg_t;

  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1) << FRAC_BITS;

  localparam cfg_t CFG_RESET = '{
    box_lengths:    {NUM_AXES{LEN_ONE}},
    inv_rows:       '0,
    tr_rows:        '0,
    triclinic_mode: 1'b0
  };

  // Per-lane results handed to the merge stage.
  typedef struct packed {
    logic signed [WR_W-1:0] wrap;
    logic signed [S_W-1:0]  frac;
  } lane_res_t;

  // Entry j of a packed matrix row.
  function automatic ent_t row_ent(input row_t row, input int j);
    return ent_t'(row[j*ENT_W +: ENT_W]);
  endfunction

  // Divide by 2^SBITS, rounding to nearest with ties away from zero.
  function automatic logic signed [WIDE_W-1:0] round_sbits(
    input logic signed [WIDE_W-1:0] v
  );
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] qm;
    mag = v[WIDE_W-1] ? $unsigned(-v) : $unsigned(v);
    qm  = (mag + (WIDE_W'(1) << (SBITS - 1))) >> SBITS;
    return v[WIDE_W-1] ? -$signed(qm) : $signed(qm);
  endfunction

  // Clamp to the signed coordinate range.
  function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return coord_t'(hi[COORD_WIDTH-1:0]);
    end else if (v < lo) begin
      return coord_t'(lo[COORD_WIDTH-1:0]);
    end
    return coord_t'(v[COORD_WIDTH-1:0]);
  endfunction

endpackage

// ----- src/pmi_in_if.sv -----
`timescale 1ns / 1ps

interface pmi_in_if;
  import pmi_pkg::*;

  logic   valid;
  logic   ready;
  coord_t first_x;
  coord_t first_y;
  coord_t first_z;
  coord_t second_x;
  coord_t second_y;
  coord_t second_z;

  modport source (
    output valid, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

// ----- src/pmi_out_if.sv -----
`timescale 1ns / 1ps

interface pmi_out_if;
  import pmi_pkg::*;

  logic   valid;
  logic   ready;
  coord_t disp_x;
  coord_t disp_y;
  coord_t disp_z;

  modport source (output valid, disp_x, disp_y, disp_z, input ready);
  modport sink (input valid, disp_x, disp_y, disp_z, output ready);
endinterface

// ----- src/pmi_cfg_if.sv -----
`timescale 1ns / 1ps

interface pmi_cfg_if;
  import pmi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/periodic_minimum_image.sv -----
`timescale 1ns / 1ps
// Minimum-image displacement of two 3D positions under periodic boundaries.
// in_ch carries a pair of positions (first, second); out_ch returns one
// displacement first minus second per pair, in the same order. Both are
// valid/ready channels; a transfer happens when valid and ready are high.
// cfg_ch writes the box registers by index and is always ready; write it
// only while no pair is in flight.
// Throughput: one pair per cycle while out_ch does not stall. The per-axis
// remainder pipeline, which resolves one quotient bit per stage, makes up most
// of the path from the input transfer to out_ch.valid.
// Three lanes, one per axis, each run the orthogonal wrap and one row of
// the inverse-matrix product; a merge stage applies the transform matrix,
// rounds, saturates and selects the mode.
// Reset clears the pipeline and sets unit box lengths, zero matrices and
// orthogonal mode. When out_ch stalls, the whole pipeline holds and
// in_ch.ready drops; it returns the same cycle the result is taken.
module periodic_minimum_image (
  input  logic    clk,
  input  logic    rst_n,
  pmi_in_if.sink   in_ch,
  pmi_out_if.source out_ch,
  pmi_cfg_if.sink  cfg_ch
);
  import pmi_pkg::*;

  // Configuration registers.
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_BOX_LENGTHS: cfg_nxt.box_lengths = cfg_ch.data[NUM_AXES*LEN_W-1:0];
        REG_INV_ROW0:    cfg_nxt.inv_rows[0] = cfg_ch.data;
        REG_INV_ROW1:    cfg_nxt.inv_rows[1] = cfg_ch.data;
        REG_INV_ROW2:    cfg_nxt.inv_rows[2] = cfg_ch.data;
        REG_TR_ROW0:     cfg_nxt.tr_rows[0] = cfg_ch.data;
        REG_TR_ROW1:     cfg_nxt.tr_rows[1] = cfg_ch.data;
        REG_TR_ROW2:     cfg_nxt.tr_rows[2] = cfg_ch.data;
        REG_TRIC_MODE:   cfg_nxt.triclinic_mode = cfg_ch.data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline control: everything advances unless the output is stalled.
  logic                en;
  logic                in_xfer;
  logic [PIPE_LEN-1:0] v_r;
  logic [PIPE_LEN-1:0] v_nxt;

  assign en           = !v_r[PIPE_LEN-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign v_nxt        = en ? {v_r[PIPE_LEN-2:0], in_xfer} : v_r;
  assign out_ch.valid = v_r[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Input register: raw per-axis difference.
  diff_t d_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= DIFF_W'(in_ch.first_x) - DIFF_W'(in_ch.second_x);
      d_r[1] <= DIFF_W'(in_ch.first_y) - DIFF_W'(in_ch.second_y);
      d_r[2] <= DIFF_W'(in_ch.first_z) - DIFF_W'(in_ch.second_z);
    end
  end

  // One lane per axis.
  lane_res_t lres [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    pmi_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .len     (cfg_r.box_lengths[i*LEN_W +: LEN_W]),
      .inv_row (cfg_r.inv_rows[i]),
      .d_own   (d_r[i]),
      .d_all   (d_r),
      .res     (lres[i])
    );
  end

  // Merge: transform back, round, saturate, select.
  coord_t disp [NUM_AXES];

  pmi_merge u_merge (
    .clk       (clk),
    .en        (en),
    .tr_rows   (cfg_r.tr_rows),
    .tric_mode (cfg_r.triclinic_mode),
    .res       (lres),
    .disp      (disp)
  );

  assign out_ch.disp_x = disp[0];
  assign out_ch.disp_y = disp[1];
  assign out_ch.disp_z = disp[2];

  // A stalled output blocks new pairs.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("periodic_minimum_image: input accepted while output stalled");

  // An accepted pair enters the first pipeline stage.
  a_xfer_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v_r[0])
    else $error("periodic_minimum_image: accepted pair lost at entry");

  // During a stall no item moves or disappears inside the pipeline.
  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(v_r))
    else $error("periodic_minimum_image: pipeline moved during stall");

endmodule

// ----- src/pmi_lane.sv -----
`timescale 1ns / 1ps

module pmi_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [pmi_pkg::LEN_W-1:0] len,
  input  pmi_pkg::row_t     inv_row,
  input  pmi_pkg::diff_t    d_own,
  input  pmi_pkg::diff_t    d_all [pmi_pkg::NUM_AXES],
  output pmi_pkg::lane_res_t res
);
  import pmi_pkg::*;

  // Orthogonal wrap: remainder pipeline, one quotient bit per stage.
  logic [T_W-1:0]   rem_r [T_W+1];
  logic             neg_r [T_W+1];
  diff_t            dd_r  [T_W+1];
  logic [LEN_W-1:0] len_r [T_W+1];

  logic [LEN_W-1:0]      h_a;
  logic signed [T_W-1:0] t_a;

  assign h_a = len >> 1;
  assign t_a = T_W'(d_own) + $signed(T_W'(h_a));

  // Entry stage: shift by half a box and take the magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= t_a[T_W-1] ? $unsigned(-t_a) : $unsigned(t_a);
      neg_r[0] <= t_a[T_W-1];
      dd_r[0]  <= d_own;
      len_r[0] <= len;
    end
  end

  // Restoring remainder, from the top shift down to zero.
  for (genvar k = 1; k <= T_W; k++) begin : g_div
    logic [T_W+LEN_W-1:0] sub;
    assign sub = {{T_W{1'b0}}, len_r[k-1]} << (T_W - k);

    always_ff @(posedge clk) begin
      if (en) begin
        if ((T_W+LEN_W)'(rem_r[k-1]) >= sub) begin
          rem_r[k] <= rem_r[k-1] - sub[T_W-1:0];
        end else begin
          rem_r[k] <= rem_r[k-1];
        end
        neg_r[k] <= neg_r[k-1];
        dd_r[k]  <= dd_r[k-1];
        len_r[k] <= len_r[k-1];
      end
    end
  end

  // Floor correction for negative values, then remove the half-box shift.
  logic [T_W-1:0]         rem_f;
  logic signed [WR_W-1:0] len_s;
  logic signed [WR_W-1:0] h_s;
  logic signed [WR_W-1:0] r_f;
  logic signed [WR_W-1:0] wrap_f;
  logic signed [WR_W-1:0] wrap_r;

  always_comb begin
    rem_f = rem_r[T_W];
    len_s = $signed(WR_W'(len_r[T_W]));
    h_s   = $signed(WR_W'(len_r[T_W] >> 1));
    if (neg_r[T_W] && (rem_f != '0)) begin
      r_f = len_s - $signed(WR_W'(rem_f));
    end else begin
      r_f = $signed(WR_W'(rem_f));
    end
    if (len_r[T_W] == '0) begin
      wrap_f = WR_W'(dd_r[T_W]);
    end else begin
      wrap_f = r_f - h_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrap_r <= wrap_f;
    end
  end

  // Triclinic: one row of the inverse matrix, products then sum and round.
  logic signed [P1_W-1:0]   p_r [NUM_AXES];
  logic signed [ACC1_W-1:0] acc_q;
  logic signed [WIDE_W-1:0] wide_q;
  logic signed [WIDE_W-1:0] q_q;
  logic signed [WIDE_W-1:0] s_q;
  logic signed [S_W-1:0]    s_r [LANE_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        p_r[j] <= P1_W'(row_ent(inv_row, j) * d_all[j]);
      end
    end
  end

  always_comb begin
    acc_q = '0;
    for (int j = 0; j < NUM_AXES; j++) begin
      acc_q = acc_q + ACC1_W'(p_r[j]);
    end
    wide_q = WIDE_W'(acc_q);
    q_q    = round_sbits(wide_q);
    s_q    = wide_q - (q_q <<< SBITS);
  end

  // Fractional remainder, delayed to line up with the wrap result.
  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= S_W'(s_q);
      for (int k = 1; k < LANE_LAT - 1; k++) begin
        s_r[k] <= s_r[k-1];
      end
    end
  end

  assign res.wrap = wrap_r;
  assign res.frac = s_r[LANE_LAT-2];

  // The remainder leaving the divider is always below the box length.
  a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r[T_W] != '0) |-> (rem_r[T_W] < T_W'(len_r[T_W])))
    else $error("pmi_lane: remainder not reduced below box length");

endmodule

// ----- src/pmi_merge.sv -----
`timescale 1ns / 1ps

module pmi_merge (
  input  logic               clk,
  input  logic               en,
  input  pmi_pkg::rows_t     tr_rows,
  input  logic               tric_mode,
  input  pmi_pkg::lane_res_t res [pmi_pkg::NUM_AXES],
  output pmi_pkg::coord_t    disp [pmi_pkg::NUM_AXES]
);
  import pmi_pkg::*;

  logic signed [P2_W-1:0] p2_r [NUM_AXES][NUM_AXES];
  logic signed [WR_W-1:0] wr_r [NUM_AXES];
  coord_t                 disp_r [NUM_AXES];
  coord_t                 disp_nxt [NUM_AXES];

  // Products of the transform matrix with the lane fractions.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          p2_r[i][j] <= P2_W'(row_ent(tr_rows[i], j) * $signed(res[j].frac));
        end
        wr_r[i] <= res[i].wrap;
      end
    end
  end

  // Row sums, rounding, saturation and mode selection.
  always_comb begin
    logic signed [ACC2_W-1:0] acc;
    for (int i = 0; i < NUM_AXES; i++) begin
      acc = '0;
      for (int j = 0; j < NUM_AXES; j++) begin
        acc = acc + ACC2_W'(p2_r[i][j]);
      end
      if (tric_mode) begin
        disp_nxt[i] = sat_coord(round_sbits(WIDE_W'(acc)));
      end else begin
        disp_nxt[i] = sat_coord(WIDE_W'(wr_r[i]));
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      disp_r <= disp_nxt;
    end
  end

  assign disp = disp_r;

endmodule

// ----- test/pmi_checker.sv -----
`timescale 1ns / 1ps

module pmi_checker
  import pmi_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  pmi_in_if     in_ch,
  pmi_out_if    out_ch,
  pmi_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending_count
);

  typedef struct {
    coord_t dx;
    coord_t dy;
    coord_t dz;
  } disp_t;

  // Shadow copy of the box registers.
  logic [59:0] box_len_q;
  logic [62:0] inv_q [3];
  logic [62:0] tr_q [3];
  logic        tric_q;

  disp_t expected_disp [$];

  function automatic longint ent_of(input logic [62:0] row, input int j);
    logic signed [ENT_W-1:0] e;
    e = row[j*ENT_W +: ENT_W];
    return longint'(e);
  endfunction

  // Divide by 2^SBITS, nearest, ties away from zero.
  function automatic longint rnd_sbits(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (SBITS - 1))) >>> SBITS;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint wrap_len(input longint d, input longint len);
    longint h;
    longint t;
    longint q;
    if (len == 0) return d;
    h = len / 2;
    t = d + h;
    q = t / len;
    if ((t % len) != 0 && t < 0) q--;
    return t - q * len - h;
  endfunction

  function automatic coord_t clamp_coord(input longint v);
    longint hi;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return coord_t'(v);
  endfunction

  function automatic disp_t min_image(input coord_t a [3], input coord_t b [3]);
    longint d [3];
    longint s [3];
    longint r [3];
    longint acc;
    disp_t res;
    for (int i = 0; i < 3; i++) d[i] = longint'(a[i]) - longint'(b[i]);
    if (!tric_q) begin
      for (int i = 0; i < 3; i++)
        r[i] = wrap_len(d[i], longint'(box_len_q[i*LEN_W +: LEN_W]));
    end else begin
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += ent_of(inv_q[i], j) * d[j];
        s[i] = acc - rnd_sbits(acc) * (64'sd1 <<< SBITS);
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += ent_of(tr_q[i], j) * s[j];
        r[i] = rnd_sbits(acc);
      end
    end
    res.dx = clamp_coord(r[0]);
    res.dy = clamp_coord(r[1]);
    res.dz = clamp_coord(r[2]);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input coord_t got, input coord_t want);
    $display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_disp.size();

  // Track register writes, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    coord_t a [3];
    coord_t b [3];
    disp_t w;
    if (!rst_n) begin
      box_len_q <= CFG_RESET.box_lengths;
      for (int i = 0; i < 3; i++) begin
        inv_q[i] <= '0;
        tr_q[i] <= '0;
      end
      tric_q <= 1'b0;
      expected_disp.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_BOX_LENGTHS: box_len_q <= cfg_ch.data[59:0];
          REG_INV_ROW0: inv_q[0] <= cfg_ch.data;
          REG_INV_ROW1: inv_q[1] <= cfg_ch.data;
          REG_INV_ROW2: inv_q[2] <= cfg_ch.data;
          REG_TR_ROW0: tr_q[0] <= cfg_ch.data;
          REG_TR_ROW1: tr_q[1] <= cfg_ch.data;
          REG_TR_ROW2: tr_q[2] <= cfg_ch.data;
          REG_TRIC_MODE: tric_q <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        a = '{in_ch.first_x, in_ch.first_y, in_ch.first_z};
        b = '{in_ch.second_x, in_ch.second_y, in_ch.second_z};
        expected_disp.push_back(min_image(a, b));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_disp.size() == 0) begin
          $display("%0t: result transfer with no pair outstanding", $realtime);
          fail_count++;
        end else begin
          w = expected_disp.pop_front();
          if (out_ch.disp_x !== w.dx) report_mismatch("disp_x", out_ch.disp_x, w.dx);
          if (out_ch.disp_y !== w.dy) report_mismatch("disp_y", out_ch.disp_y, w.dy);
          if (out_ch.disp_z !== w.dz) report_mismatch("disp_z", out_ch.disp_z, w.dz);
        end
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pmi_pkg::*;

  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;
  longint cycle_count;

  pmi_in_if  in_ch ();
  pmi_out_if out_ch ();
  pmi_cfg_if cfg_ch ();

  periodic_minimum_image i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  pmi_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One register write; valid is then dropped again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for all results, then let the pipeline drain fully.
  task automatic drain();
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_LEN + 4) @(negedge clk);
  endtask

  // Send one pair, holding valid until the transfer; idle beforehand at random.
  task automatic send_pair(input coord_t fx, fy, fz, sx, sy, sz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.first_x <= fx;
    in_ch.first_y <= fy;
    in_ch.first_z <= fz;
    in_ch.second_x <= sx;
    in_ch.second_y <= sy;
    in_ch.second_z <= sz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? coord_t'(24'h7fffff - $urandom_range(15))
                                  : coord_t'(24'h800000 + $urandom_range(15));
      default: return coord_t'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [62:0] rand_row(input int span);
    logic [62:0] r;
    for (int j = 0; j < 3; j++)
      r[j*ENT_W +: ENT_W] = ($urandom_range(3) == 0) ? ENT_W'($urandom)
                          : ENT_W'($signed($urandom_range(2 * span)) - span);
    return r;
  endfunction

  task automatic random_pairs(input int count);
    coord_t fx, fy, fz;
    for (int k = 0; k < count; k++) begin
      fx = rand_coord();
      fy = rand_coord();
      fz = rand_coord();
      if ($urandom_range(1))
        send_pair(fx, fy, fz, rand_coord(), rand_coord(), rand_coord());
      else
        send_pair(fx, fy, fz, fx - coord_t'($signed($urandom_range(65535)) - 32768),
                  fy + coord_t'($urandom_range(4096)), fz - coord_t'($urandom_range(4096)));
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic random_config(input bit tric);
    write_reg(REG_BOX_LENGTHS, CFG_DATA_W'({$urandom, $urandom}));
    for (int i = 0; i < 3; i++) begin
      write_reg(CFG_IDX_W'(REG_INV_ROW0 + i), rand_row(1 << 15));
      write_reg(CFG_IDX_W'(REG_TR_ROW0 + i), rand_row(1 << 14));
    end
    write_reg(REG_TRIC_MODE, CFG_DATA_W'(tric));
  endtask

  localparam coord_t CMAX = 24'h7fffff;
  localparam coord_t CMIN = 24'h800000;

  initial begin
    rst_n = 1'b0;
    hold_off = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 55;
    in_ch.valid = 1'b0;
    {in_ch.first_x, in_ch.first_y, in_ch.first_z} = '0;
    {in_ch.second_x, in_ch.second_y, in_ch.second_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset box of 1.0, extremes and ties of the wrap.
    send_pair(CMAX, CMIN, 0, CMIN, CMAX, 0);
    send_pair(512, -512, 1024, 0, 0, 0);
    send_pair(511, -513, 0, 0, 0, 1);
    send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    // Zero length on one axis and the maximum on another.
    in_ch.valid <= 1'b0;
    drain();
    write_reg(REG_BOX_LENGTHS, CFG_DATA_W'({20'hfffff, 20'd0, 20'd3000}));
    send_pair(CMAX, CMAX, 1500, CMIN, CMIN, 0);
    send_pair(1500, 77, -1500, 0, 0, 0);
    send_pair(-1501, CMIN, 24'h07ffff, 0, CMAX, -24'h080000);
    in_ch.valid <= 1'b0;
    drain();
    // Triclinic with identity-like matrices, then extreme entries for saturation.
    write_reg(REG_INV_ROW0, {21'd0, 21'd0, 21'd512});
    write_reg(REG_INV_ROW1, {21'd0, 21'd512, 21'd0});
    write_reg(REG_INV_ROW2, {21'd512, 21'd0, 21'd0});
    write_reg(REG_TR_ROW0, {21'd0, 21'd0, 21'd1048575});
    write_reg(REG_TR_ROW1, {21'd0, 21'd1048575, 21'd0});
    write_reg(REG_TR_ROW2, {21'h100000, 21'd0, 21'd0});
    write_reg(REG_TRIC_MODE, CFG_DATA_W'(1));
    send_pair(CMAX, CMIN, 512, CMIN, CMAX, 0);
    send_pair(1024, -1024, 3000, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(REG_INV_ROW0, {3{21'h0fffff}});
    write_reg(REG_INV_ROW1, {3{21'h100000}});
    write_reg(REG_TR_ROW0, {3{21'h100000}});
    send_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_pair(12345, -999, 7, -54321, 888, CMAX);
    in_ch.valid <= 1'b0;
    drain();

    // Random phases over several settings, with the idling schedule.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 55;
        recv_idle_pct = 6;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config(ph[0]);
      if (ph == 4) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(negedge clk);
            hold_off = 1'b0;
          end
          random_pairs(75);
        join
      end else begin
        random_pairs(70);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
